[hdl/bcs_pkg.sv]
// Shared types, constants and register indexes for the three-bucket sorter.
package bcs_pkg;

  localparam int unsigned DEF_MAX_ITEMS = 16;
  localparam int unsigned CFG_W = 31;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned KEY_W = 34;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] LOW_TOP_RST = 31'd9;
  localparam logic [CFG_W-1:0] MID_BOT_RST = 31'd10;
  localparam logic [CFG_W-1:0] MID_TOP_RST = 31'd50;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_TOP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_BOT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_TOP = 2'd2;

  localparam logic [1:0] BKT_LOW = 2'd0;
  localparam logic [1:0] BKT_MID = 2'd1;
  localparam logic [1:0] BKT_OTHER = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    final_item;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic [1:0]              bucket_number;
    logic                    final_result;
    logic                    items_dropped;
  } out_item_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

[hdl/bcs_classify.sv]
// Bucket classifier: turns a sample into its sort key (bucket, biased value).
module bcs_classify (
  input  logic signed [31:0] sample,
  input  logic [30:0]        low_top,
  input  logic [30:0]        mid_bot,
  input  logic [30:0]        mid_top,
  output bcs_pkg::key_t      key
);
  import bcs_pkg::*;

  logic       nonneg;
  logic [1:0] bucket;

  assign nonneg = ~sample[VAL_W-1];

  always_comb begin
    if (nonneg && (sample[VAL_W-2:0] <= low_top)) begin
      bucket = BKT_LOW;
    end else if (nonneg && (sample[VAL_W-2:0] >= mid_bot) &&
                 (sample[VAL_W-2:0] <= mid_top)) begin
      bucket = BKT_MID;
    end else begin
      bucket = BKT_OTHER;
    end
  end

  // flip the sign bit so unsigned order matches signed order
  assign key = {bucket, ~sample[VAL_W-1], sample[VAL_W-2:0]};

endmodule

[hdl/bcs_cell.sv]
// One cell of the insertion chain: holds a key, shifts right on insert, left on drain.
module bcs_cell (
  input  logic               clk,
  input  bcs_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  bcs_pkg::key_t      new_key,
  input  bcs_pkg::key_t      left_key,
  input  logic               left_take,
  input  bcs_pkg::key_t      right_key,
  output bcs_pkg::key_t      key,
  output logic               take
);
  import bcs_pkg::*;

  key_t key_r;
  key_t key_nxt;

  // the new key belongs at or before this cell
  assign take = ~occupied | (new_key < key_r);

  always_comb begin
    key_nxt = key_r;
    if (ctrl.insert && take) begin
      key_nxt = left_take ? left_key : new_key;
    end else if (ctrl.shift) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule

[hdl/bucket_classify_sort.sv]
// Top level of the three-bucket sorter: config registers, control and the cell chain.
//
// Values load one per cycle while busy is low; each is classified on entry and
// dropped into place in a row of MAX_ITEMS compare-and-shift cells, so no
// separate sort pass exists. The word marked final_item starts the burst: from
// the next cycle busy is high and the chain shifts its head out on out_data, one
// word per cycle with out_valid high, bucket 0 first, each bucket ascending.
// The receiver cannot stall the burst. After the burst the block is empty and busy
// falls. Values beyond MAX_ITEMS in one set are discarded and flagged by
// items_dropped on every word of that burst.
module bucket_classify_sort #(
  parameter int unsigned MAX_ITEMS = bcs_pkg::DEF_MAX_ITEMS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bcs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output bcs_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [bcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcs_pkg::CFG_W-1:0]     cfg_wdata
);
  import bcs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [CFG_W-1:0] low_top_r, mid_bot_r, mid_top_r;
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  logic       accept;
  logic       full;
  cell_ctrl_t ctrl;
  key_t       new_key;
  key_t       cell_key  [MAX_ITEMS];
  logic       cell_take [MAX_ITEMS];
  logic       draining;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_top_r <= LOW_TOP_RST;
      mid_bot_r <= MID_BOT_RST;
      mid_top_r <= MID_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_TOP: low_top_r <= cfg_wdata;
        REG_MID_BOT: mid_bot_r <= cfg_wdata;
        REG_MID_TOP: mid_top_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bcs_classify u_classify (
    .sample  (in_data.sample_value),
    .low_top (low_top_r),
    .mid_bot (mid_bot_r),
    .mid_top (mid_top_r),
    .key     (new_key)
  );

  assign draining = (state_r == ST_DRAIN);
  assign busy     = draining;
  assign accept   = start & ~busy;
  assign full     = (count_r == CNT_FULL);

  assign ctrl.insert = accept & ~full;
  assign ctrl.shift  = draining;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_ONE;
          end
          if (in_data.final_item) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        count_nxt = count_r - CNT_ONE;
        // last word out: empty the set
        if (count_r == CNT_ONE) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    key_t left_key;
    logic left_take;
    key_t right_key;

    if (i == 0) begin : g_head
      assign left_key  = new_key;
      assign left_take = 1'b0;
    end else begin : g_body
      assign left_key  = cell_key[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    bcs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CNT_W'(i) < count_r),
      .new_key   (new_key),
      .left_key  (left_key),
      .left_take (left_take),
      .right_key (right_key),
      .key       (cell_key[i]),
      .take      (cell_take[i])
    );
  end

  assign out_valid              = draining;
  assign out_data.sorted_value  = {~cell_key[0][VAL_W-1], cell_key[0][VAL_W-2:0]};
  assign out_data.bucket_number = cell_key[0][KEY_W-1:VAL_W];
  assign out_data.final_result  = draining & (count_r == CNT_ONE);
  assign out_data.items_dropped = ovf_r;

  // burst ends after its final word
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.final_result |=> !out_valid)
    else $error("output continued after final word");

  // a burst never stops short of its final word
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_result |=> out_valid)
    else $error("burst broke off before final word");

  // a final item always starts a burst
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.final_item |=> out_valid)
    else $error("final item did not start a burst");

  // keys leave in nondecreasing order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_data.final_result) |->
      (cell_key[0] >= $past(cell_key[0])))
    else $error("burst out of order");

endmodule
